// ----- sv/dgsp_pkg.sv -----
`timescale 1ns / 1ps
// Package for the dense graph shortest path core: word types, codes and constants.
// Depends on nothing; imported by dense_graph_shortest_path_core and its testbench.
package dgsp_pkg;

	localparam int VERTICES_DEF = 8;
	localparam int IDX_W        = 3;
	localparam int WEIGHT_W     = 14;

	localparam logic [WEIGHT_W-1:0] NO_EDGE = 14'd10000;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_RUN  = 1'b1;

	typedef struct packed {
		logic                action;
		logic [IDX_W-1:0]    row;
		logic [IDX_W-1:0]    col;
		logic [WEIGHT_W-1:0] edge_weight;
		logic [IDX_W-1:0]    start_vertex;
	} cmd_t;

	typedef struct packed {
		logic [IDX_W-1:0]    vertex;
		logic [WEIGHT_W-1:0] path_length;
		logic                last;
	} result_t;

endpackage

// ----- sv/dense_graph_shortest_path_core.sv -----
`timescale 1ns / 1ps
// Dense graph shortest path core: weight matrix in a synchronous RAM, shortest path sequencer.
// Depends on dgsp_pkg.
//
//   channel   signals              direction   handshake
//   command   start, busy, cmd     in          taken when start is high and busy is low
//   result    strobe, result       out         one word per cycle while strobe is high
//
// A load word is written to the matrix in the cycle it is taken; loads follow back to back.
// A run takes VERTICES passes, one matrix row per pass read through the single RAM read port,
// then VERTICES result words, last one marked.
// Reset clears the control state only; matrix entries are undefined until loaded.
// The receiver cannot stall; busy falls as the final result word goes out, so the next
// word can be taken in that cycle.
module dense_graph_shortest_path_core #(
	parameter int VERTICES = dgsp_pkg::VERTICES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  dgsp_pkg::cmd_t   cmd,
	output logic             strobe,
	output dgsp_pkg::result_t result
);
	import dgsp_pkg::*;

	localparam int VW = (VERTICES > 1) ? $clog2(VERTICES) : 1;
	localparam int CW = $clog2(VERTICES + 1);
	localparam int AW = 2 * VW;
	localparam int MD = 1 << AW;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_PASS = 3'b010,
		S_EMIT = 3'b100
	} state_t;

	typedef logic [VW-1:0] idx_t;

	state_t              state_q;
	logic [CW-1:0]       cnt_q;
	idx_t                pass_q;
	idx_t                u_q;
	logic [WEIGHT_W-1:0] du_q;
	idx_t                min_idx_q;
	logic [WEIGHT_W-1:0] min_val_q;
	logic [VERTICES-1:0] settled_q;
	logic [WEIGHT_W-1:0] dist_q [VERTICES];
	logic                valid_s1;
	idx_t                w_s1;
	logic [WEIGHT_W-1:0] rd_s1;
	logic                strobe_q;
	result_t             result_q;

	logic [WEIGHT_W-1:0] mem [MD];

	logic                accept;
	logic                load_we;
	logic                run_go;
	logic [AW-1:0]       wr_addr;
	logic [AW-1:0]       rd_addr;
	logic [WEIGHT_W-1:0] wr_data;
	logic                issue;
	idx_t                cnt_idx;
	logic [WEIGHT_W:0]   sum;
	logic [WEIGHT_W-1:0] cand;
	logic [WEIGHT_W-1:0] old_d;
	logic [WEIGHT_W-1:0] new_d;
	logic                better;
	idx_t                min_idx_next;
	logic [WEIGHT_W-1:0] min_val_next;
	logic                pass_end;

	assign busy    = (state_q != S_IDLE);
	assign accept  = start && (state_q == S_IDLE);
	assign load_we = accept && (cmd.action == ACT_LOAD) && (32'(cmd.row) < VERTICES)
		&& (32'(cmd.col) < VERTICES);
	assign run_go  = accept && (cmd.action == ACT_RUN) && (32'(cmd.start_vertex) < VERTICES);
	assign wr_addr = {VW'(cmd.row), VW'(cmd.col)};
	assign wr_data = (cmd.edge_weight > NO_EDGE) ? NO_EDGE : cmd.edge_weight;
	assign cnt_idx = cnt_q[VW-1:0];
	assign issue   = (state_q == S_PASS) && (cnt_q < CW'(VERTICES));
	assign rd_addr = {u_q, cnt_idx};

	always_ff @(posedge clk) begin
		if (load_we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_s1 <= mem[rd_addr];
	end

	always_comb begin
		sum   = {1'b0, du_q} + {1'b0, rd_s1};
		cand  = (sum >= {1'b0, NO_EDGE}) ? NO_EDGE : sum[WEIGHT_W-1:0];
		old_d = dist_q[w_s1];
		if (pass_q == '0) begin
			new_d = (w_s1 == u_q) ? '0 : rd_s1;
		end else if (settled_q[w_s1]) begin
			new_d = old_d;
		end else begin
			new_d = (cand < old_d) ? cand : old_d;
		end
		better       = valid_s1 && !settled_q[w_s1] && (new_d < min_val_q);
		min_idx_next = better ? w_s1 : min_idx_q;
		min_val_next = better ? new_d : min_val_q;
		pass_end     = valid_s1 && (w_s1 == VW'(VERTICES - 1));
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			dist_q[w_s1] <= new_d;
		end
		w_s1 <= cnt_idx;
		if (state_q == S_EMIT) begin
			result_q.vertex      <= IDX_W'(cnt_idx);
			result_q.path_length <= dist_q[cnt_idx];
			result_q.last        <= (cnt_idx == VW'(VERTICES - 1));
		end
		if (run_go) begin
			u_q  <= VW'(cmd.start_vertex);
			du_q <= '0;
		end else if (pass_end && (pass_q != VW'(VERTICES - 1))) begin
			u_q  <= min_idx_next;
			du_q <= min_val_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			pass_q    <= '0;
			min_idx_q <= '0;
			min_val_q <= '1;
			settled_q <= '0;
			valid_s1  <= 1'b0;
			strobe_q  <= 1'b0;
		end else begin
			valid_s1 <= issue;
			strobe_q <= (state_q == S_EMIT);
			case (state_q)
				S_IDLE: begin
					if (run_go) begin
						state_q   <= S_PASS;
						cnt_q     <= '0;
						pass_q    <= '0;
						min_idx_q <= '0;
						min_val_q <= '1;
						for (int i = 0; i < VERTICES; i++) begin
							settled_q[i] <= (VW'(i) == VW'(cmd.start_vertex));
						end
					end
				end
				S_PASS: begin
					if (issue) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (pass_end) begin
						cnt_q     <= '0;
						min_idx_q <= '0;
						min_val_q <= '1;
						if (pass_q == VW'(VERTICES - 1)) begin
							state_q <= S_EMIT;
						end else begin
							pass_q                  <= pass_q + 1'b1;
							settled_q[min_idx_next] <= 1'b1;
						end
					end else begin
						min_idx_q <= min_idx_next;
						min_val_q <= min_val_next;
					end
				end
				S_EMIT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_idx == VW'(VERTICES - 1)) begin
						state_q <= S_IDLE;
						cnt_q   <= '0;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

	// Result words only follow a period of being busy.
	a_strobe_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("result word issued while the core was idle");

	// The words of one run are contiguous.
	a_run_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !result.last) |=> strobe)
		else $error("gap inside the result words of a run");

	// Nothing follows the final word of a run.
	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.last) |=> !strobe)
		else $error("result word after the final word of a run");

	// A valid run command makes the core busy.
	a_run_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (cmd.action == ACT_RUN) && (32'(cmd.start_vertex) < VERTICES))
		|=> busy)
		else $error("run command taken without the core turning busy");

endmodule

// ----- dv/dense_graph_shortest_path_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for dense_graph_shortest_path_core: loads edge weights, runs
// shortest path searches and checks every result word against a built-in predictor or fixed words.
// Depends on dgsp_pkg and dense_graph_shortest_path_core.
module dense_graph_shortest_path_core_tb;
	import dgsp_pkg::*;

	localparam int VERTICES        = VERTICES_DEF;
	localparam int QUIET_LIMIT     = 4000;
	localparam int RUN_CYCLES      = VERTICES * (VERTICES + 2) + 16;
	localparam int WORDS_PER_PHASE = 6;

	typedef struct packed {
		cmd_t                word;
		logic                typed;
		logic [WEIGHT_W-1:0] far_length;
	} plan_row_t;

	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    start  = 1'b0;
	cmd_t    cmd    = '0;
	logic    busy;
	logic    strobe;
	result_t result;

	logic [WEIGHT_W-1:0] weight_matrix [VERTICES][VERTICES];
	result_t             distance_queue [$];
	plan_row_t           directed_plan [$];
	result_t             due_word;
	int                  failures     = 0;
	int                  quiet_cycles = 0;
	int                  gap_percent  = 0;

	dense_graph_shortest_path_core #(
		.VERTICES(VERTICES)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.cmd   (cmd),
		.strobe(strobe),
		.result(result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic cmd_t make_word(logic act, int r, int c, int w, int s);
		cmd_t word;
		word.action       = act;
		word.row          = r[IDX_W-1:0];
		word.col          = c[IDX_W-1:0];
		word.edge_weight  = w[WEIGHT_W-1:0];
		word.start_vertex = s[IDX_W-1:0];
		return word;
	endfunction

	function automatic cmd_t random_word();
		int pick;
		int w;
		pick = $urandom_range(99);
		if (pick < 25) begin
			w = NO_EDGE;
		end else if (pick < 30) begin
			w = $urandom_range(16383, 10001);
		end else if (pick < 40) begin
			w = 0;
		end else if (pick < 80) begin
			w = $urandom_range(100, 1);
		end else begin
			w = $urandom_range(9999, 101);
		end
		return make_word(($urandom_range(99) < 20) ? ACT_RUN : ACT_LOAD, $urandom_range(7),
			$urandom_range(7), w, $urandom_range(7));
	endfunction

	// Loads update the matrix; a run settles one vertex per pass and queues the distances.
	task automatic predict_distances(input cmd_t word);
		logic [WEIGHT_W-1:0] path_est [VERTICES];
		bit                  done [VERTICES];
		result_t             word_out;
		int                  least;
		int                  u;
		int                  cand;
		if (word.action == ACT_LOAD) begin
			weight_matrix[word.row][word.col] =
				(word.edge_weight > NO_EDGE) ? NO_EDGE : word.edge_weight;
			return;
		end
		for (int i = 0; i < VERTICES; i++) begin
			path_est[i] = weight_matrix[word.start_vertex][i];
			done[i]     = 1'b0;
		end
		done[word.start_vertex]     = 1'b1;
		path_est[word.start_vertex] = '0;
		for (int k = 0; k + 1 < VERTICES; k++) begin
			least = 32'h7fffffff;
			u     = 0;
			for (int i = 0; i < VERTICES; i++) begin
				if (!done[i] && int'(path_est[i]) < least) begin
					least = path_est[i];
					u     = i;
				end
			end
			done[u] = 1'b1;
			for (int w = 0; w < VERTICES; w++) begin
				cand = int'(path_est[u]) + int'(weight_matrix[u][w]);
				if (cand >= int'(NO_EDGE))
					cand = NO_EDGE;
				if (!done[w] && cand < int'(path_est[w]))
					path_est[w] = cand[WEIGHT_W-1:0];
			end
		end
		for (int i = 0; i < VERTICES; i++) begin
			word_out.vertex      = i[IDX_W-1:0];
			word_out.path_length = path_est[i];
			word_out.last        = (i == VERTICES - 1);
			distance_queue.push_back(word_out);
		end
	endtask

	task automatic send_word(input cmd_t word);
		while ($urandom_range(99) < gap_percent) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd   <= word;
		do @(posedge clk); while (busy);
	endtask

	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (distance_queue.size() == 0) begin
				$error("unexpected result word: vertex %0d, path_length %0d, last %0d",
					result.vertex, result.path_length, result.last);
				failures++;
			end else begin
				due_word = distance_queue.pop_front();
				if (result.vertex !== due_word.vertex) begin
					$error("vertex: expected %0d, got %0d", due_word.vertex, result.vertex);
					failures++;
				end
				if (result.path_length !== due_word.path_length) begin
					$error("path_length: expected %0d, got %0d", due_word.path_length,
						result.path_length);
					failures++;
				end
				if (result.last !== due_word.last) begin
					$error("last: expected %0d, got %0d", due_word.last, result.last);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("dense_graph_shortest_path_core test failed");
				$finish;
			end
		end
	end

	initial begin
		plan_row_t step;
		result_t   word_out;
		cmd_t      word;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		gap_percent = 20;

		// Every matrix entry is written before the first run reads it.
		for (int r = 0; r < VERTICES; r++) begin
			for (int c = 0; c < VERTICES; c++) begin
				word = make_word(ACT_LOAD, r, c, NO_EDGE, r + c);
				send_word(word);
				predict_distances(word);
			end
		end

		directed_plan.push_back('{make_word(ACT_RUN, 0, 0, 0, 0), 1'b1, NO_EDGE});
		directed_plan.push_back('{make_word(ACT_RUN, 7, 7, 16383, 7), 1'b1, NO_EDGE});
		directed_plan.push_back('{make_word(ACT_LOAD, 0, 1, 16383, 7), 1'b0, '0});
		directed_plan.push_back('{make_word(ACT_RUN, 0, 0, 0, 0), 1'b1, NO_EDGE});
		directed_plan.push_back('{make_word(ACT_LOAD, 0, 1, 10001, 0), 1'b0, '0});
		directed_plan.push_back('{make_word(ACT_RUN, 0, 0, 0, 0), 1'b1, NO_EDGE});
		directed_plan.push_back('{make_word(ACT_LOAD, 0, 1, 0, 0), 1'b0, '0});
		directed_plan.push_back('{make_word(ACT_LOAD, 1, 2, 9999, 0), 1'b0, '0});
		directed_plan.push_back('{make_word(ACT_LOAD, 2, 3, 1, 0), 1'b0, '0});
		directed_plan.push_back('{make_word(ACT_RUN, 0, 0, 0, 0), 1'b0, '0});
		directed_plan.push_back('{make_word(ACT_LOAD, 0, 3, 5, 0), 1'b0, '0});
		directed_plan.push_back('{make_word(ACT_LOAD, 0, 4, 5, 0), 1'b0, '0});
		directed_plan.push_back('{make_word(ACT_LOAD, 3, 2, 3, 0), 1'b0, '0});
		directed_plan.push_back('{make_word(ACT_LOAD, 4, 5, 2, 0), 1'b0, '0});
		directed_plan.push_back('{make_word(ACT_RUN, 0, 0, 0, 0), 1'b0, '0});
		directed_plan.push_back('{make_word(ACT_LOAD, 7, 6, 10000, 0), 1'b0, '0});
		directed_plan.push_back('{make_word(ACT_LOAD, 7, 0, 1, 0), 1'b0, '0});
		directed_plan.push_back('{make_word(ACT_LOAD, 7, 7, 0, 0), 1'b0, '0});
		directed_plan.push_back('{make_word(ACT_RUN, 0, 0, 0, 7), 1'b0, '0});
		directed_plan.push_back('{make_word(ACT_LOAD, 1, 0, 9999, 0), 1'b0, '0});
		directed_plan.push_back('{make_word(ACT_RUN, 0, 0, 0, 1), 1'b0, '0});
		directed_plan.push_back('{make_word(ACT_RUN, 0, 0, 0, 3), 1'b0, '0});

		foreach (directed_plan[n]) begin
			step = directed_plan[n];
			send_word(step.word);
			if (step.typed) begin
				for (int v = 0; v < VERTICES; v++) begin
					word_out.vertex      = v[IDX_W-1:0];
					word_out.path_length = (v == step.word.start_vertex) ? '0 : step.far_length;
					word_out.last        = (v == VERTICES - 1);
					distance_queue.push_back(word_out);
				end
			end else begin
				predict_distances(step.word);
			end
		end

		// Each phase ends with the sender holding off until every result word is in.
		for (int phase = 0; phase < 3; phase++) begin
			gap_percent = (phase == 0) ? 20 : (phase == 1) ? 76 : 0;
			for (int k = 0; k < WORDS_PER_PHASE; k++) begin
				word = random_word();
				send_word(word);
				predict_distances(word);
			end
			start <= 1'b0;
			do @(posedge clk); while (distance_queue.size() != 0);
		end

		repeat (RUN_CYCLES) @(posedge clk);
		if (failures == 0 && distance_queue.size() == 0) begin
			$display("dense_graph_shortest_path_core test passed");
		end else begin
			$display("dense_graph_shortest_path_core test failed");
		end
		$finish;
	end

endmodule
